// ===== rtl/cvam_pkg.sv =====
// Shared types and constants for the concat view address map.
package cvam_pkg;

  localparam int FIELD_DIMS   = 4;   // dimensions carried by the item fields
  localparam int SIZE_W       = 16;  // width of one size or origin field
  localparam int SLOT_W       = 4;
  localparam int INDEX_W      = 32;
  localparam int VIEW_COUNT_W = 5;
  localparam int CFG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = 16;
  localparam int DIV_STEPS_W  = 5;   // counts the INDEX_W quotient bits

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_OUT_DIM_0  = 3'd0,
    REG_OUT_DIM_1  = 3'd1,
    REG_OUT_DIM_2  = 3'd2,
    REG_OUT_DIM_3  = 3'd3,
    REG_VIEW_COUNT = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic               mode;
    logic [SLOT_W-1:0]  view_slot;
    logic [SIZE_W-1:0]  origin_0;
    logic [SIZE_W-1:0]  origin_1;
    logic [SIZE_W-1:0]  origin_2;
    logic [SIZE_W-1:0]  origin_3;
    logic [SIZE_W-1:0]  extent_0;
    logic [SIZE_W-1:0]  extent_1;
    logic [SIZE_W-1:0]  extent_2;
    logic [SIZE_W-1:0]  extent_3;
    logic [INDEX_W-1:0] out_index;
  } cvam_req_t;

  typedef struct packed {
    logic               found;
    logic [SLOT_W-1:0]  source_view;
    logic [INDEX_W-1:0] source_index;
  } cvam_rsp_t;

endpackage

// ===== rtl/cvam_if.sv =====
// Valid/ready channel interfaces for request and result items.
interface cvam_req_if;
  import cvam_pkg::*;
  logic      valid;
  logic      ready;
  cvam_req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface cvam_rsp_if;
  import cvam_pkg::*;
  logic      valid;
  logic      ready;
  cvam_rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/cvam_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module cvam_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/cvam_div.sv =====
// Radix-2 restoring divider: 32-bit dividend by a narrow divisor, one bit per cycle.
module cvam_div #(
  parameter int DIVISOR_W = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [cvam_pkg::INDEX_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]         divisor,   // held stable while busy
  output logic                         done,
  output logic [cvam_pkg::INDEX_W-1:0] quotient,
  output logic [DIVISOR_W-1:0]         remainder
);
  import cvam_pkg::*;

  logic                   busy;
  logic [DIV_STEPS_W-1:0] step;
  logic [INDEX_W-1:0]     quo;
  logic [DIVISOR_W-1:0]   rem;
  logic [DIVISOR_W:0]     trial;
  logic [DIVISOR_W:0]     diff;
  logic                   ge;

  assign trial = {rem, quo[INDEX_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign ge    = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '1;
      end else if (busy) begin
        step <= step - 1'b1;
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[INDEX_W-2:0], ge};
      // without a subtract the trial is below the divisor, so it fits
      rem <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

// ===== rtl/concat_view_address_map_top.sv =====
// Concat view address map: output element index to source view and offset.
//
//  channel   dir  handshake      payload
//  request   in   valid/ready    mode, view_slot, origin_0..3, extent_0..3, out_index
//  result    out  valid/ready    found, source_view, source_index
//  cfg       in   cfg_we         cfg_index, cfg_data (write only)
//
// Load item (mode 1): table written on accept, result then emitted from S_DONE.
// Map item (mode 0): for each dimension one pass through the shared divider, then the views
// are scanned through the table RAM's registered read, then the offset multiply-add runs one
// dimension at a time; one item in flight, request.ready only when idle.
// A new item is taken while the previous result still waits in the output register.
// Synchronous reset; the view table is not cleared.
module concat_view_address_map_top #(
  parameter int RANK      = 4,
  parameter int MAX_VIEWS = 16,
  parameter int DIM_BITS  = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [cvam_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [cvam_pkg::CFG_DATA_W-1:0]  cfg_data,
  cvam_req_if.sink                         request,
  cvam_rsp_if.source                       result
);
  import cvam_pkg::*;

  // dimensions past the fourth have size 1, origin 0, extent 1 and drop out
  localparam int FD    = (RANK < FIELD_DIMS) ? RANK : FIELD_DIMS;
  localparam int DW    = (FD > 1) ? $clog2(FD) : 1;
  localparam int AW    = (MAX_VIEWS > 1) ? $clog2(MAX_VIEWS) : 1;
  localparam int VW    = $clog2(MAX_VIEWS + 1);
  localparam int ROW_W = 2 * FD * DIM_BITS;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_DSTART   = 7'b0000010,
    S_DWAIT    = 7'b0000100,
    S_SCAN_RD  = 7'b0001000,
    S_SCAN_CHK = 7'b0010000,
    S_OFFS     = 7'b0100000,
    S_DONE     = 7'b1000000
  } state_t;

  state_t                    state;
  logic [DIM_BITS-1:0]       out_dim [FD];
  logic [VIEW_COUNT_W-1:0]   view_count;
  logic [INDEX_W-1:0]        rest;
  logic [DW-1:0]             dim_idx;
  logic [DIM_BITS-1:0]       coord [FD];
  logic [VW-1:0]             view;
  logic [INDEX_W-1:0]        acc;
  logic                      res_found;
  logic [SLOT_W-1:0]         res_view;
  logic [INDEX_W-1:0]        res_index;
  logic                      out_valid;
  cvam_rsp_t                 out_data;

  logic                      accept;
  logic                      emit;
  logic                      dim_wr;
  logic [1:0]                dim_sel;
  logic [VW-1:0]             count_c;
  logic [VW-1:0]             view_inc;
  logic [DIM_BITS-1:0]       cur_dim;
  logic [SIZE_W-1:0]         org_f [FIELD_DIMS];
  logic [SIZE_W-1:0]         ext_f [FIELD_DIMS];
  logic [ROW_W-1:0]          wdata;
  logic [ROW_W-1:0]          rdata;
  logic [DIM_BITS-1:0]       row_org [FD];
  logic [DIM_BITS-1:0]       row_ext [FD];
  logic                      view_hit;
  logic [INDEX_W-1:0]        mac;
  logic                      table_we;
  logic                      div_start;
  logic                      div_done;
  logic [INDEX_W-1:0]        div_quo;
  logic [DIM_BITS-1:0]       div_rem;

  assign accept   = request.valid && (state == S_IDLE);
  assign emit     = (state == S_DONE) && (!out_valid || result.ready);
  assign count_c  = (32'(view_count) > MAX_VIEWS) ? VW'(MAX_VIEWS) : VW'(view_count);
  assign view_inc = view + 1'b1;
  assign cur_dim  = out_dim[dim_idx];

  assign org_f[0] = request.payload.origin_0;
  assign org_f[1] = request.payload.origin_1;
  assign org_f[2] = request.payload.origin_2;
  assign org_f[3] = request.payload.origin_3;
  assign ext_f[0] = request.payload.extent_0;
  assign ext_f[1] = request.payload.extent_1;
  assign ext_f[2] = request.payload.extent_2;
  assign ext_f[3] = request.payload.extent_3;

  // table row: origins in the low half, extents in the high half
  always_comb begin
    for (int k = 0; k < FD; k++) begin
      wdata[k*DIM_BITS +: DIM_BITS]        = org_f[k][DIM_BITS-1:0];
      wdata[(FD+k)*DIM_BITS +: DIM_BITS]   = ext_f[k][DIM_BITS-1:0];
      row_org[k] = rdata[k*DIM_BITS +: DIM_BITS];
      row_ext[k] = rdata[(FD+k)*DIM_BITS +: DIM_BITS];
    end
  end

  always_comb begin
    view_hit = 1'b1;
    for (int k = 0; k < FD; k++) begin
      if ((coord[k] < row_org[k]) ||
          ({1'b0, coord[k]} >= ({1'b0, row_org[k]} + {1'b0, row_ext[k]}))) begin
        view_hit = 1'b0;
      end
    end
  end

  // Horner form of the row-major offset, one dimension per cycle
  assign mac = (acc * INDEX_W'(row_ext[dim_idx])) +
               INDEX_W'(coord[dim_idx] - row_org[dim_idx]);

  assign table_we  = accept && request.payload.mode &&
                     (32'(request.payload.view_slot) < MAX_VIEWS);
  assign div_start = (state == S_DSTART) && (cur_dim != '0);

  cvam_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_VIEWS)
  ) u_table (
    .clk   (clk),
    .we    (table_we),
    .waddr (AW'(request.payload.view_slot)),
    .wdata (wdata),
    .re    (state == S_SCAN_RD),
    .raddr (view[AW-1:0]),
    .rdata (rdata)
  );

  cvam_div #(
    .DIVISOR_W (DIM_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (rest),
    .divisor   (cur_dim),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_comb begin
    dim_wr  = 1'b0;
    dim_sel = 2'd0;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_OUT_DIM_0: begin dim_wr = 1'b1; dim_sel = 2'd0; end
        REG_OUT_DIM_1: begin dim_wr = 1'b1; dim_sel = 2'd1; end
        REG_OUT_DIM_2: begin dim_wr = 1'b1; dim_sel = 2'd2; end
        REG_OUT_DIM_3: begin dim_wr = 1'b1; dim_sel = 2'd3; end
        default: begin dim_wr = 1'b0; dim_sel = 2'd0; end
      endcase
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      view_count <= '0;
      for (int k = 0; k < FD; k++) begin
        out_dim[k] <= DIM_BITS'(1);
      end
    end else begin
      for (int k = 0; k < FD; k++) begin
        if (dim_wr && (dim_sel == 2'(k))) begin
          out_dim[k] <= cfg_data[DIM_BITS-1:0];
        end
      end
      if (cfg_we && (cfg_reg_t'(cfg_index) == REG_VIEW_COUNT)) begin
        view_count <= cfg_data[VIEW_COUNT_W-1:0];
      end

      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (request.valid) begin
            state <= request.payload.mode ? S_DONE : S_DSTART;
          end
        end
        S_DSTART: begin
          // zero size: empty tensor, nothing maps
          state <= (cur_dim == '0) ? S_DONE : S_DWAIT;
        end
        S_DWAIT: begin
          if (div_done) begin
            if (dim_idx != '0) begin
              state <= S_DSTART;
            end else if ((div_quo != '0) || (count_c == '0)) begin
              state <= S_DONE;
            end else begin
              state <= S_SCAN_RD;
            end
          end
        end
        S_SCAN_RD: begin
          state <= S_SCAN_CHK;
        end
        S_SCAN_CHK: begin
          if (view_hit) begin
            state <= S_OFFS;
          end else if (view_inc == count_c) begin
            state <= S_DONE;
          end else begin
            state <= S_SCAN_RD;
          end
        end
        S_OFFS: begin
          if (dim_idx == DW'(FD - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (emit) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          rest      <= request.payload.out_index;
          dim_idx   <= DW'(FD - 1);
          res_found <= 1'b0;
          res_view  <= '0;
          res_index <= '0;
        end
      end
      S_DSTART: begin
        view <= '0;
      end
      S_DWAIT: begin
        if (div_done) begin
          coord[dim_idx] <= div_rem;
          rest           <= div_quo;
          if (dim_idx != '0) begin
            dim_idx <= dim_idx - 1'b1;
          end
        end
      end
      S_SCAN_RD: begin
        acc <= '0;
      end
      S_SCAN_CHK: begin
        if (view_hit) begin
          dim_idx <= '0;
        end else begin
          view <= view_inc;
        end
      end
      S_OFFS: begin
        acc     <= mac;
        dim_idx <= dim_idx + 1'b1;
        if (dim_idx == DW'(FD - 1)) begin
          res_found <= 1'b1;
          res_view  <= SLOT_W'(view);
          res_index <= mac;
        end
      end
      S_DONE: begin
        if (emit) begin
          out_data.found        <= res_found;
          out_data.source_view  <= res_view;
          out_data.source_index <= res_index;
        end
      end
      default: begin
        acc <= acc;
      end
    endcase
  end

  assign request.ready  = (state == S_IDLE);
  assign result.valid   = out_valid;
  assign result.payload = out_data;

endmodule

// ===== rtl/cvam_checker.sv =====
// Port-level checker for the concat view address map, bound to the top level.
module cvam_checker (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input cvam_pkg::cvam_rsp_t rsp_payload
);
  import cvam_pkg::*;

  // one item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request taken while an item is in flight");

  // a miss carries no view and no offset
  a_miss_is_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_payload.found) |->
      (rsp_payload.source_view == '0) && (rsp_payload.source_index == '0))
    else $error("miss result with nonzero view or offset");

  a_reset_clears_result: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid right after reset");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_payload)))
    else $error("stalled result dropped or changed");

endmodule

bind concat_view_address_map_top cvam_checker u_cvam_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (request.valid),
  .req_ready   (request.ready),
  .rsp_valid   (result.valid),
  .rsp_ready   (result.ready),
  .rsp_payload (result.payload)
);
